@@ src/sssf_pkg.sv @@
// shared types, codes and helpers of the stiff string stepper
`timescale 1ns / 1ps
package sssf_pkg;

  // least grid point count the scheme works with
  localparam int LEAST_POINTS = 6;

  // command codes; any other code reads a point
  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic [2:0] REG_CENTRE      = 3'd0;
  localparam logic [2:0] REG_EDGE_CENTRE = 3'd1;
  localparam logic [2:0] REG_NEAR        = 3'd2;
  localparam logic [2:0] REG_FAR         = 3'd3;
  localparam logic [2:0] REG_PAST        = 3'd4;
  localparam logic [2:0] REG_PAST_NEAR   = 3'd5;
  localparam logic [2:0] REG_REST        = 3'd6;
  localparam logic [2:0] REG_POINTS      = 3'd7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_DRAIN,
    ST_READ,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         point_index;
    logic signed [31:0] amount;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [31:0] point_value;
    logic               index_error;
    logic               saturated;
  } res_beat_t;

  // stencil pipeline status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic clip;
  } stc_status_t;

  // row slot one further on in the rotation, modulo three
  function automatic logic [1:0] next_row(input logic [1:0] r);
    logic [1:0] n;
    case (r)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // row slot two further on in the rotation, modulo three
  function automatic logic [1:0] prev_row(input logic [1:0] r);
    logic [1:0] n;
    case (r)
      2'd0:    n = 2'd2;
      2'd1:    n = 2'd0;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

@@ src/sssf_chan_if.sv @@
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
interface sssf_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/stiff_string_fdtd_step.sv @@
// top level of the fixed point stiff string time stepper
`timescale 1ns / 1ps
// usage:
//   cmd carries one command beat (step, add to a point, read a point); res
//   returns exactly one beat per command with the current row value at
//   point_index, an index error flag and a clip flag.
//   configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the
//   user must write only while no command is outstanding, unchecked by the block.
// sequencing:
//   read or add: the point is read, an add writes it back, and the result
//   is registered. step: the sweep reads one grid point per cycle through
//   the single read port of the row memory, then the product pipeline
//   drains and the reported point is read back.
//   one command is worked on at a time.
// reset:
//   registers return to their defaults, then a clearing pass zeroes all
//   MAX_POINTS words of the row memory; cmd.ready stays low until it is done.
// stalls:
//   a finished result sits in the output register; a new command is taken
//   meanwhile and waits only at its end until res is free.
module stiff_string_fdtd_step #(
  parameter int MAX_POINTS    = 256,
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  sssf_chan_if.sink   cmd,
  sssf_chan_if.source res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sssf_pkg::*;

  localparam int V  = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam int NW = (CW > 9) ? CW : 9;
  localparam int RW = (V > 32) ? V : 32;

  // configuration registers
  logic signed [31:0] centre_coef, edge_centre_coef, near_coef, far_coef;
  logic signed [31:0] past_coef, past_near_coef, rest_level;
  logic [8:0]         num_points;

  // derived settings
  logic [CW-1:0]        n_pts;
  logic [NW-1:0]        np_x;
  logic signed [RW-1:0] rest_x;
  logic [RW-V:0]        rest_top;
  logic signed [V-1:0]  rest;

  // sequencer / stencil / memory wiring
  stc_status_t    stc_status;
  logic           issue;
  logic [CW-1:0]  issue_k;
  logic [1:0]     rot;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [3*V-1:0] rd_data;
  logic           ctl_wr_en, stc_wr_en, mem_wr_en;
  logic [AW-1:0]  ctl_wr_addr, stc_wr_addr, mem_wr_addr;
  logic [3*V-1:0] ctl_wr_data, stc_wr_data, mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_coef      <= '0;
      edge_centre_coef <= '0;
      near_coef        <= '0;
      far_coef         <= '0;
      past_coef        <= '0;
      past_near_coef   <= '0;
      rest_level       <= '0;
      num_points       <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE:      centre_coef      <= cfg_data;
        REG_EDGE_CENTRE: edge_centre_coef <= cfg_data;
        REG_NEAR:        near_coef        <= cfg_data;
        REG_FAR:         far_coef         <= cfg_data;
        REG_PAST:        past_coef        <= cfg_data;
        REG_PAST_NEAR:   past_near_coef   <= cfg_data;
        REG_REST:        rest_level       <= cfg_data;
        REG_POINTS:      num_points       <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // point count clamped into the supported range
  always_comb begin
    np_x = NW'(num_points);
    if (np_x < NW'(LEAST_POINTS)) begin
      n_pts = CW'(LEAST_POINTS);
    end else if (np_x > NW'(MAX_POINTS)) begin
      n_pts = CW'(MAX_POINTS);
    end else begin
      n_pts = np_x[CW-1:0];
    end
  end

  // rest level clipped to the value width, not reported as a clip
  always_comb begin
    rest_x   = RW'(rest_level);
    rest_top = rest_x[RW-1:V-1];
    if ((&rest_top) || !(|rest_top)) begin
      rest = rest_x[V-1:0];
    end else if (rest_x[RW-1]) begin
      rest = {1'b1, {(V-1){1'b0}}};
    end else begin
      rest = {1'b0, {(V-1){1'b1}}};
    end
  end

  sssf_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .n_pts   (n_pts),
    .status  (stc_status),
    .issue   (issue),
    .issue_k (issue_k),
    .rot     (rot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (ctl_wr_en),
    .wr_addr (ctl_wr_addr),
    .wr_data (ctl_wr_data)
  );

  sssf_stencil #(
    .MAX_POINTS    (MAX_POINTS),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_stencil (
    .clk            (clk),
    .rst            (rst),
    .issue          (issue),
    .issue_k        (issue_k),
    .n_pts          (n_pts),
    .rot            (rot),
    .coef_centre    (centre_coef),
    .coef_edge      (edge_centre_coef),
    .coef_near      (near_coef),
    .coef_far       (far_coef),
    .coef_past      (past_coef),
    .coef_past_near (past_near_coef),
    .rest           (rest),
    .rd_data        (rd_data),
    .wr_en          (stc_wr_en),
    .wr_addr        (stc_wr_addr),
    .wr_data        (stc_wr_data),
    .status         (stc_status)
  );

  // the stencil writes only during a step sweep, the sequencer never then
  assign mem_wr_en   = stc_wr_en | ctl_wr_en;
  assign mem_wr_addr = stc_wr_en ? stc_wr_addr : ctl_wr_addr;
  assign mem_wr_data = stc_wr_en ? stc_wr_data : ctl_wr_data;

  sssf_row_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (3 * VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ src/sssf_row_mem.sv @@
// simple dual port memory holding all three rows of one grid point per word
`timescale 1ns / 1ps
module sssf_row_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/sssf_stencil.sv @@
// streaming stencil datapath: window, products, rounding, saturation, write-back
`timescale 1ns / 1ps
module sssf_stencil #(
  parameter int MAX_POINTS    = 256,
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  issue,
  input  logic [$clog2(MAX_POINTS+2)-1:0]       issue_k,
  input  logic [$clog2(MAX_POINTS+2)-1:0]       n_pts,
  input  logic [1:0]                            rot,
  input  logic signed [31:0]                    coef_centre,
  input  logic signed [31:0]                    coef_edge,
  input  logic signed [31:0]                    coef_near,
  input  logic signed [31:0]                    coef_far,
  input  logic signed [31:0]                    coef_past,
  input  logic signed [31:0]                    coef_past_near,
  input  logic signed [VALUE_WIDTH-1:0]         rest,
  input  logic [3*VALUE_WIDTH-1:0]              rd_data,
  output logic                                  wr_en,
  output logic [$clog2(MAX_POINTS)-1:0]         wr_addr,
  output logic [3*VALUE_WIDTH-1:0]              wr_data,
  output sssf_pkg::stc_status_t                 status
);
  import sssf_pkg::*;

  localparam int V   = VALUE_WIDTH;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 2);
  localparam int WW  = 3 * V;
  localparam int PW  = V + 34;
  localparam int ACW = V + 37;
  localparam logic signed [ACW-1:0] HALF = ACW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [V-1:0]   VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0]   VMIN = {1'b1, {(V-1){1'b0}}};

  // read data stage
  logic          s0_valid;
  logic [CW-1:0] s0_k;
  // window stage, win[0] newest
  logic [WW-1:0] win [5];
  logic          sw_valid;
  logic [CW-1:0] sw_l;
  // operand stage
  logic                 s1_valid, s1_end;
  logic [AW-1:0]        s1_l;
  logic [WW-1:0]        s1_word;
  logic signed [31:0]   s1_ca;
  logic signed [V-1:0]  s1_op_a, s1_op_d;
  logic signed [V:0]    s1_op_b, s1_op_e;
  logic signed [V+1:0]  s1_op_c;
  // product stage
  logic                 s2_valid, s2_end;
  logic [AW-1:0]        s2_l;
  logic [WW-1:0]        s2_word;
  logic signed [PW-1:0] p_a, p_b, p_c, p_d, p_e;
  // partial sum stage
  logic                  s3_valid, s3_end;
  logic [AW-1:0]         s3_l;
  logic [WW-1:0]         s3_word;
  logic signed [ACW-1:0] s_x, s_y;
  logic                  wr_clip;

  logic [1:0]          cu_sel, pv_sel;
  logic signed [V-1:0] cu_v [5];
  logic signed [V-1:0] pv_v [5];
  logic signed [V+1:0] rest2, far_sum;
  logic                is_first, is_last, is_end;

  logic signed [ACW-1:0] acc, shifted;
  logic [ACW-V:0]        acc_top;
  logic signed [V-1:0]   new_val, put_val;
  logic                  fits;
  logic [WW-1:0]         new_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      sw_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      wr_en    <= 1'b0;
    end else begin
      s0_valid <= issue;
      sw_valid <= s0_valid && (s0_k >= CW'(2));
      s1_valid <= sw_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      wr_en    <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_k <= issue_k;
    if (s0_valid) begin
      win[0] <= rd_data;
      for (int i = 1; i < 5; i++) begin
        win[i] <= win[i-1];
      end
    end
    sw_l <= s0_k - CW'(2);
  end

  // operand selection around the window centre
  always_comb begin
    cu_sel = next_row(rot);
    pv_sel = prev_row(rot);
    for (int i = 0; i < 5; i++) begin
      cu_v[i] = win[i][cu_sel*V +: V];
      pv_v[i] = win[i][pv_sel*V +: V];
    end
    rest2    = (V+2)'(rest) + (V+2)'(rest);
    is_first = (sw_l == CW'(1));
    is_last  = (sw_l == n_pts - CW'(2));
    is_end   = (sw_l == '0) || (sw_l == n_pts - CW'(1));
    if (is_first) begin
      far_sum = (V+2)'(cu_v[0]) + rest2;
    end else if (is_last) begin
      far_sum = (V+2)'(cu_v[4]) + rest2;
    end else begin
      far_sum = (V+2)'(cu_v[0]) + (V+2)'(cu_v[4]);
    end
  end

  always_ff @(posedge clk) begin
    s1_end  <= is_end;
    s1_l    <= sw_l[AW-1:0];
    s1_word <= win[2];
    s1_ca   <= (is_first || is_last) ? coef_edge : coef_centre;
    s1_op_a <= cu_v[2];
    s1_op_b <= (V+1)'(cu_v[1]) + (V+1)'(cu_v[3]);
    s1_op_c <= far_sum;
    s1_op_d <= pv_v[2];
    s1_op_e <= (V+1)'(pv_v[1]) + (V+1)'(pv_v[3]);
  end

  // five products, one per weight
  always_ff @(posedge clk) begin
    s2_end  <= s1_end;
    s2_l    <= s1_l;
    s2_word <= s1_word;
    p_a     <= PW'(s1_ca) * PW'(s1_op_a);
    p_b     <= PW'(coef_near) * PW'(s1_op_b);
    p_c     <= PW'(coef_far) * PW'(s1_op_c);
    p_d     <= PW'(coef_past) * PW'(s1_op_d);
    p_e     <= PW'(coef_past_near) * PW'(s1_op_e);
  end

  always_ff @(posedge clk) begin
    s3_end  <= s2_end;
    s3_l    <= s2_l;
    s3_word <= s2_word;
    s_x     <= ACW'(p_a) + ACW'(p_b) - ACW'(p_c);
    s_y     <= ACW'(p_d) - ACW'(p_e) + HALF;
  end

  // round half up, then clip to the value width; end points take the rest level
  always_comb begin
    acc     = s_x + s_y;
    shifted = acc >>> FRACTION_BITS;
    acc_top = shifted[ACW-1:V-1];
    fits    = (&acc_top) || !(|acc_top);
    if (fits) begin
      new_val = shifted[V-1:0];
    end else if (shifted[ACW-1]) begin
      new_val = VMIN;
    end else begin
      new_val = VMAX;
    end
    put_val  = s3_end ? rest : new_val;
    new_word = s3_word;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) == rot) begin
        new_word[k*V +: V] = put_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= s3_l;
    wr_data <= new_word;
    wr_clip <= !s3_end && !fits;
  end

  assign status.busy = s0_valid | sw_valid | s1_valid | s2_valid | s3_valid | wr_en;
  assign status.clip = wr_en & wr_clip;

endmodule

@@ src/sssf_ctrl.sv @@
// command sequencer: memory clearing, step sweep, add and read, result register
`timescale 1ns / 1ps
module sssf_ctrl #(
  parameter int MAX_POINTS  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  sssf_chan_if.sink                       cmd,
  sssf_chan_if.source                     res,
  input  logic [$clog2(MAX_POINTS+2)-1:0] n_pts,
  input  sssf_pkg::stc_status_t           status,
  output logic                            issue,
  output logic [$clog2(MAX_POINTS+2)-1:0] issue_k,
  output logic [1:0]                      rot,
  output logic                            rd_en,
  output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  input  logic [3*VALUE_WIDTH-1:0]        rd_data,
  output logic                            wr_en,
  output logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
  output logic [3*VALUE_WIDTH-1:0]        wr_data
);
  import sssf_pkg::*;

  localparam int V  = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam int SW = ((V > 32) ? V : 32) + 1;
  localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};

  state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic [1:0]         cmd_q;
  logic [7:0]         idx_q;
  logic signed [31:0] amount_q;
  logic               bad_q;
  logic               sat_flag;
  logic signed [31:0] hold_value;
  logic               res_valid;
  res_beat_t          res_q;

  logic                is_add;
  logic [1:0]          cu_sel, pv_sel;
  logic signed [V-1:0] cu_old, pv_old, cu_new, pv_new;
  logic signed [SW-1:0] cu_sum, pv_sum;
  logic [SW-V:0]       cu_top, pv_top;
  logic                cu_fits, pv_fits;
  logic [3*V-1:0]      add_word;
  logic                res_free;

  assign is_add   = (cmd_q == CMD_ADD);
  assign res_free = !res_valid || res.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CW'(MAX_POINTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.payload.command == CMD_STEP) ? ST_STEP : ST_READ;
        end
      end
      ST_STEP: begin
        if (cnt == n_pts + CW'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.busy) state_next = ST_READ;
      end
      ST_READ:   state_next = ST_RDWAIT;
      ST_RDWAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // add arithmetic on the word just read, each sum clipped
  always_comb begin
    cu_sel  = next_row(rot);
    pv_sel  = prev_row(rot);
    cu_old  = rd_data[cu_sel*V +: V];
    pv_old  = rd_data[pv_sel*V +: V];
    cu_sum  = SW'(cu_old) + SW'(amount_q);
    pv_sum  = SW'(pv_old) + SW'(amount_q);
    cu_top  = cu_sum[SW-1:V-1];
    pv_top  = pv_sum[SW-1:V-1];
    cu_fits = (&cu_top) || !(|cu_top);
    pv_fits = (&pv_top) || !(|pv_top);
    cu_new  = cu_fits ? cu_sum[V-1:0] : (cu_sum[SW-1] ? VMIN : VMAX);
    pv_new  = pv_fits ? pv_sum[V-1:0] : (pv_sum[SW-1] ? VMIN : VMAX);
    add_word = rd_data;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) == cu_sel) begin
        add_word[k*V +: V] = cu_new;
      end else if (2'(k) == pv_sel) begin
        add_word[k*V +: V] = pv_new;
      end
    end
  end

  // outputs
  always_comb begin
    cmd.ready = 1'b0;
    issue     = 1'b0;
    issue_k   = cnt;
    rd_en     = 1'b0;
    rd_addr   = AW'(idx_q);
    wr_en     = 1'b0;
    wr_addr   = AW'(idx_q);
    wr_data   = add_word;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
        wr_data = '0;
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      ST_STEP: begin
        issue   = 1'b1;
        rd_en   = (cnt < n_pts);
        rd_addr = cnt[AW-1:0];
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_RDWAIT: begin
        wr_en = is_add && !bad_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rot       <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: cnt <= cnt + CW'(1);
        ST_IDLE:  cnt <= '0;
        ST_STEP:  cnt <= cnt + CW'(1);
        ST_DRAIN: begin
          if (!status.busy) rot <= prev_row(rot);
        end
        default: begin
        end
      endcase
      if (state == ST_FINISH && res_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // command fields, flags and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      cmd_q    <= cmd.payload.command;
      idx_q    <= cmd.payload.point_index;
      amount_q <= cmd.payload.amount;
      bad_q    <= IW'(cmd.payload.point_index) >= IW'(n_pts);
      sat_flag <= 1'b0;
    end else if (state == ST_STEP || state == ST_DRAIN) begin
      sat_flag <= sat_flag | status.clip;
    end else if (state == ST_RDWAIT) begin
      if (is_add && !bad_q) begin
        sat_flag <= sat_flag | !cu_fits | !pv_fits;
      end
      if (bad_q) begin
        hold_value <= '0;
      end else if (is_add) begin
        hold_value <= 32'(cu_new);
      end else begin
        hold_value <= 32'(cu_old);
      end
    end
    if (state == ST_FINISH && res_free) begin
      res_q.point_value <= hold_value;
      res_q.index_error <= bad_q;
      res_q.saturated   <= sat_flag;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_q;

`ifndef SYNTH
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |-> !status.busy)
    else $error("command taken while stencil pipeline busy");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    rot != 2'd3)
    else $error("row rotation out of range");

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  a_busy_in_step: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> (state == ST_STEP || state == ST_DRAIN))
    else $error("stencil active outside a step");
`endif

endmodule
